// File: hw/rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared types, sector codes and scaling constants of the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

	localparam int unsigned HUE_W = 9;
	localparam int unsigned CH_W  = 8;

	// largest legal hue, degrees per sector, full scale of a channel
	localparam logic [HUE_W-1:0] HUE_MAX    = 9'd359;
	localparam logic [6:0]       SECTOR_DEG = 7'd60;
	localparam logic [7:0]       FULL       = 8'd255;
	// 255 * 60, the denominator of the secondary channel
	localparam logic [13:0]      SECOND_DEN = 14'd15300;

	// reciprocal of 255: floor(x / 255) = (x * ZERO_RCP) >> 23 for any 16-bit x
	localparam logic [15:0] ZERO_RCP   = 16'd32897;
	localparam int unsigned ZERO_SHIFT = 23;
	// reciprocal of 15300: ceil(2^36 / 15300), exact for any 22-bit numerator
	localparam logic [22:0] SECOND_RCP   = 23'd4491470;
	localparam int unsigned SECOND_SHIFT = 36;

	// sector codes, one per 60-degree slice of the hue circle
	localparam logic [2:0] SEC_RED_YELLOW  = 3'd0;
	localparam logic [2:0] SEC_YELLOW_GRN  = 3'd1;
	localparam logic [2:0] SEC_GRN_CYAN    = 3'd2;
	localparam logic [2:0] SEC_CYAN_BLUE   = 3'd3;
	localparam logic [2:0] SEC_BLUE_MAG    = 3'd4;
	localparam logic [2:0] SEC_MAG_RED     = 3'd5;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  saturation;
		logic [CH_W-1:0]  value;
	} hsv_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// stage 1: sector and distance from the sector's grey edge
	typedef struct packed {
		logic [2:0]      sector;
		logic [5:0]      k;
		logic [CH_W-1:0] saturation;
		logic [CH_W-1:0] value;
	} sector_t;

	// stage 2: the two first products
	typedef struct packed {
		logic [2:0]      sector;
		logic [CH_W-1:0] value;
		logic [15:0]     zero_prod;
		logic [13:0]     sat_prod;
	} prod_t;

	// stage 3: zero channel done, secondary numerator ready for scaling
	typedef struct packed {
		logic [2:0]      sector;
		logic [CH_W-1:0] value;
		logic [CH_W-1:0] zero;
		logic [21:0]     second_num;
	} scaled_t;

	// per-stage flow control from the top level
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} stage_en_t;

endpackage

// File: hw/rtl/hsv_to_rgb_converter.sv
// a request's result is valid once it has passed the stage 1, 2, 3 and 4 registers
// throughput: one request per cycle unless stalled; four-stage pipeline, no feedback
// a stalled output holds every full stage behind it; bubbles are filled while stalled
// reset: arst_n clears all stage valid bits asynchronously; data is not reset
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Converts hue, saturation and value into 8-bit red, green and blue.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          hsv_valid,
	output logic          hsv_stall,
	input  hsv_pkg::hsv_t hsv,
	output logic          rgb_valid,
	input  logic          rgb_stall,
	output hsv_pkg::rgb_t rgb
);
	import hsv_pkg::*;

	stage_en_t en;
	logic      valid_s1;
	sector_t   data_s1;
	logic      valid_s3;
	scaled_t   data_s3;
	logic      valid_s2_seen;

	// a stage moves when it is empty or the stage after it moves
	assign en.en_s4 = !rgb_valid || !rgb_stall;
	assign en.en_s3 = !valid_s3 || en.en_s4;
	assign en.en_s2 = !valid_s2_seen || en.en_s3;
	assign en.en_s1 = !valid_s1 || en.en_s2;
	assign hsv_stall = !en.en_s1;

	hsv_sector u_sector (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en.en_s1),
		.valid    (hsv_valid),
		.hsv      (hsv),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1)
	);

	hsv_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.valid_s1 (valid_s1),
		.data_s1  (data_s1),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3)
	);

	// mirror of the stage 2 valid bit for the flow control chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2_seen <= 1'b0;
		else if (en.en_s2)
			valid_s2_seen <= valid_s1;
	end

	hsv_place u_place (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en.en_s4),
		.valid_s3 (valid_s3),
		.data_s3  (data_s3),
		.valid_s4 (rgb_valid),
		.data_s4  (rgb)
	);

	// empty output register means nothing can block the input
	a_no_stall_when_empty : assert property (@(posedge clk) disable iff (!arst_n)
		!rgb_valid |-> !hsv_stall)
		else $error("input stalled with empty output stage");

	// an accepted request lands in stage 1
	a_accept_fills_s1 : assert property (@(posedge clk) disable iff (!arst_n)
		hsv_valid && !hsv_stall |=> valid_s1)
		else $error("accepted request lost at stage 1");

	// a blocked stage 1 keeps its item
	a_s1_holds : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !en.en_s2 |=> valid_s1)
		else $error("stage 1 item dropped while blocked");

endmodule

// File: hw/rtl/hsv_sector.sv
// ----------------------------------------------------------------------------
// hsv_sector
// Stage 1: clamps the hue, finds its sector and the secondary weight k.
// ----------------------------------------------------------------------------
module hsv_sector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               valid,
	input  hsv_pkg::hsv_t      hsv,
	output logic               valid_s1,
	output hsv_pkg::sector_t   data_s1
);
	import hsv_pkg::*;

	logic [HUE_W-1:0] hue_c;
	logic [2:0]       sector;
	logic [HUE_W-1:0] pair_base;
	logic [6:0]       phase;
	logic [5:0]       k;

	// saturate out-of-range hue
	assign hue_c = (hsv.hue > HUE_MAX) ? HUE_MAX : hsv.hue;

	// sector by threshold compare, exact multiples of 60 go to the higher sector
	always_comb begin
		priority if (hue_c < 9'd60)  sector = SEC_RED_YELLOW;
		else if (hue_c < 9'd120)     sector = SEC_YELLOW_GRN;
		else if (hue_c < 9'd180)     sector = SEC_GRN_CYAN;
		else if (hue_c < 9'd240)     sector = SEC_CYAN_BLUE;
		else if (hue_c < 9'd300)     sector = SEC_BLUE_MAG;
		else                         sector = SEC_MAG_RED;
	end

	// start of the 120-degree pair holding this sector
	always_comb begin
		unique case (sector[2:1])
			2'd0:    pair_base = 9'd0;
			2'd1:    pair_base = 9'd120;
			default: pair_base = 9'd240;
		endcase
	end

	// hue mod 120 folded into a triangle peaking at 60
	always_comb begin
		phase = 7'(hue_c - pair_base);
		if (phase >= SECTOR_DEG)
			k = 6'(7'd120 - phase);
		else
			k = phase[5:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1.sector     <= sector;
			data_s1.k          <= k;
			data_s1.saturation <= hsv.saturation;
			data_s1.value      <= hsv.value;
		end
	end

endmodule

// File: hw/rtl/hsv_scale.sv
// ----------------------------------------------------------------------------
// hsv_scale
// Stages 2 and 3: forms the products and scales the zero channel by 1/255.
// ----------------------------------------------------------------------------
module hsv_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  hsv_pkg::stage_en_t en,
	input  logic               valid_s1,
	input  hsv_pkg::sector_t   data_s1,
	output logic               valid_s3,
	output hsv_pkg::scaled_t   data_s3
);
	import hsv_pkg::*;

	logic        valid_s2;
	prod_t       data_s2;
	logic [5:0]  k_left;
	logic [13:0] second_fac;
	logic [31:0] zero_wide;

	// value * (255 - s) and s * (60 - k)
	assign k_left = 6'(SECTOR_DEG) - data_s1.k;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en.en_s2)
				valid_s2 <= valid_s1;
			if (en.en_s3)
				valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			data_s2.sector    <= data_s1.sector;
			data_s2.value     <= data_s1.value;
			data_s2.zero_prod <= 16'(data_s1.value) * 16'(FULL - data_s1.saturation);
			data_s2.sat_prod  <= 14'(data_s1.saturation) * 14'(k_left);
		end
	end

	// zero channel by reciprocal multiply, secondary numerator
	assign zero_wide  = 32'(data_s2.zero_prod) * 32'(ZERO_RCP);
	assign second_fac = SECOND_DEN - data_s2.sat_prod;

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			data_s3.sector     <= data_s2.sector;
			data_s3.value      <= data_s2.value;
			data_s3.zero       <= zero_wide[ZERO_SHIFT +: CH_W];
			data_s3.second_num <= 22'(data_s2.value) * 22'(second_fac);
		end
	end

endmodule

// File: hw/rtl/hsv_place.sv
// ----------------------------------------------------------------------------
// hsv_place
// Stage 4: scales the secondary channel and routes channels per sector.
// ----------------------------------------------------------------------------
module hsv_place (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             valid_s3,
	input  hsv_pkg::scaled_t data_s3,
	output logic             valid_s4,
	output hsv_pkg::rgb_t    data_s4
);
	import hsv_pkg::*;

	logic [44:0]     second_wide;
	logic [CH_W-1:0] second;
	rgb_t            rgb;

	// divide by 15300 through the reciprocal
	assign second_wide = 45'(data_s3.second_num) * 45'(SECOND_RCP);
	assign second      = second_wide[SECOND_SHIFT +: CH_W];

	// chroma, secondary and zero placement per sector
	always_comb begin
		unique case (data_s3.sector)
			SEC_RED_YELLOW: rgb = '{data_s3.value, second, data_s3.zero};
			SEC_YELLOW_GRN: rgb = '{second, data_s3.value, data_s3.zero};
			SEC_GRN_CYAN:   rgb = '{data_s3.zero, data_s3.value, second};
			SEC_CYAN_BLUE:  rgb = '{data_s3.zero, second, data_s3.value};
			SEC_BLUE_MAG:   rgb = '{second, data_s3.zero, data_s3.value};
			default:        rgb = '{data_s3.value, data_s3.zero, second};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s4 <= 1'b0;
		else if (en)
			valid_s4 <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (en)
			data_s4 <= rgb;
	end

endmodule
